[rtl/core/bls_pkg.sv]
// Package for the bounded LIFO stack: request and response payload types,
// action and status codes, and default sizes.
// No dependencies.
package bls_pkg;

    // Default store geometry
    localparam int DEF_MAX_DEPTH = 256;
    localparam int DEF_WORD_BITS = 32;

    // Field widths fixed by the interface
    localparam int DATA_BITS = 32;
    localparam int CAP_BITS  = 9;

    // Capacity register reset value
    localparam logic [CAP_BITS-1:0] CAP_RESET = 9'd256;

    // Request kinds
    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_POP  = 2'd1;
    localparam logic [1:0] ACT_PEEK = 2'd2;
    localparam logic [1:0] ACT_READ = 2'd3;

    // Response status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_BADPOS   = 2'd3;

    // Data returned for a push or on any error
    localparam logic [DATA_BITS-1:0] ERR_DATA = '1;

    typedef struct packed {
        logic [1:0]                  action;
        logic signed [DATA_BITS-1:0] push_value;
        logic [CAP_BITS-1:0]         position;
    } t_req;

    typedef struct packed {
        logic signed [DATA_BITS-1:0] read_data;
        logic [1:0]                  status;
        logic [CAP_BITS-1:0]         entry_count;
    } t_rsp;

endpackage

[rtl/core/bounded_lifo_stack.sv]
// Bounded LIFO stack top level: entry memory, fill pointer, request decode,
// read stage, capacity register and response register.
// Depends on bls_pkg.
//
//  Channel   | Direction | Handshake              | Payload
//  ----------+-----------+------------------------+----------------------------
//  request   | in        | i_req_valid/o_req_stall| i_req  (t_req)
//  response  | out       | o_rsp_valid/i_rsp_stall| o_rsp  (t_rsp)
//  capacity  | in        | i_cfg_valid/o_cfg_ready| i_cfg_data (9 bits)
//
// One request is taken per cycle unless the request side stalls. The entry
// memory is read into the read stage at the transfer edge, and the response
// register loads from the read stage when it may advance. Reset is synchronous
// and clears the fill pointer, the pipeline valids and the capacity (to 256);
// the entry memory is not cleared. The request side stalls during reset. A
// stalled response holds the read stage, which then stalls the request side.
module bounded_lifo_stack
    import bls_pkg::*;
#(
    parameter int MAX_DEPTH = DEF_MAX_DEPTH,
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_stall,
    input  t_req                i_req,
    output logic                o_rsp_valid,
    input  logic                i_rsp_stall,
    output t_rsp                o_rsp,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CAP_BITS-1:0] i_cfg_data
);

    localparam int AW   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CW   = $clog2(MAX_DEPTH + 1);
    localparam int CMPW = (CW > CAP_BITS) ? CW : CAP_BITS;

    // State
    logic [WORD_BITS-1:0] r_mem [MAX_DEPTH];
    logic [WORD_BITS-1:0] r_rd_word;
    logic [CW-1:0]        r_fill;
    logic [CAP_BITS-1:0]  r_cap;

    // Read stage
    logic                 r_s1_valid;
    logic [1:0]           r_s1_status;
    logic [CAP_BITS-1:0]  r_s1_count;
    logic                 r_s1_use_rd;

    // Response register
    logic                 r_out_valid;
    t_rsp                 r_out;

    // Decode
    logic                 s1_adv;
    logic                 accept;
    logic [CMPW-1:0]      fill_x;
    logic [CMPW-1:0]      cap_x;
    logic [CMPW-1:0]      pos_x;
    logic [CMPW-1:0]      rd_off;
    logic [CW-1:0]        fill_m1;
    logic                 full;
    logic                 empty;
    logic                 bad_pos;
    logic                 rd_en;
    logic                 wr_en;
    logic [AW-1:0]        rd_addr;
    logic [CW-1:0]        n_fill;
    logic [1:0]           n_status;
    logic [63:0]          push_ext;
    logic [63:0]          word_ext;

    // Handshake
    assign s1_adv      = !r_out_valid || !i_rsp_stall;
    assign o_req_stall = !i_rst_n || (r_s1_valid && !s1_adv);
    assign accept      = i_req_valid && !o_req_stall;
    assign o_cfg_ready = 1'b1;

    // Occupancy tests
    assign fill_x  = CMPW'(r_fill);
    assign cap_x   = CMPW'(r_cap);
    assign pos_x   = CMPW'(i_req.position);
    assign rd_off  = fill_x - pos_x;
    assign fill_m1 = r_fill - CW'(1);
    assign full    = (fill_x >= cap_x) || (fill_x >= CMPW'(MAX_DEPTH));
    assign empty   = (r_fill == '0);
    assign bad_pos = (pos_x == '0) || (pos_x > fill_x);

    // Push word: sign-extend the 32-bit field, keep the low WORD_BITS
    assign push_ext = 64'(i_req.push_value);

    // Request decode: memory access, new fill and status
    always_comb begin
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        rd_addr  = fill_m1[AW-1:0];
        n_fill   = r_fill;
        n_status = ST_OK;
        case (i_req.action)
            ACT_PUSH: begin
                if (full) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    wr_en  = 1'b1;
                    n_fill = r_fill + CW'(1);
                end
            end
            ACT_POP: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    rd_en  = 1'b1;
                    n_fill = fill_m1;
                end
            end
            ACT_PEEK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    rd_en = 1'b1;
                end
            end
            default: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else if (bad_pos) begin
                    n_status = ST_BADPOS;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = rd_off[AW-1:0];
                end
            end
        endcase
    end

    // Entry memory: one write or one registered read per transfer
    always_ff @(posedge i_clk) begin
        if (accept && wr_en) begin
            r_mem[r_fill[AW-1:0]] <= push_ext[WORD_BITS-1:0];
        end
        if (accept && rd_en) begin
            r_rd_word <= r_mem[rd_addr];
        end
    end

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= i_cfg_data;
        end
    end

    // Fill pointer and read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_fill     <= n_fill;
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_status <= n_status;
            r_s1_count  <= CAP_BITS'(n_fill);
            r_s1_use_rd <= rd_en;
        end
    end

    // Read word sign-extended to the response width
    assign word_ext = 64'($signed(r_rd_word));

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out.read_data   <= r_s1_use_rd ? word_ext[DATA_BITS-1:0] : ERR_DATA;
            r_out.status      <= r_s1_status;
            r_out.entry_count <= r_s1_count;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    // Fill pointer never passes the store depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill_x <= CMPW'(MAX_DEPTH))
        else $error("fill pointer beyond store depth");

    // A successful push raises the fill by one
    a_push_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.action == ACT_PUSH && !full) |=> r_fill == $past(r_fill) + CW'(1))
        else $error("push did not advance fill pointer");

    // An overflowing push leaves the fill untouched
    a_ovf_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.action == ACT_PUSH && full) |=> r_fill == $past(r_fill))
        else $error("overflowing push changed fill pointer");

    // Read stage is not overwritten while it waits on the response register
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> r_s1_valid && $stable(r_s1_status) && $stable(r_s1_count))
        else $error("stalled read stage lost its item");

    // An empty status only ever leaves with a zero count
    a_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_EMPTY) |-> r_out.entry_count == '0)
        else $error("empty status with nonzero count");

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the bounded LIFO stack: directed table, then
// random request phases at several capacities, checked by an in-bench stack model.
// Depends on bls_pkg and bounded_lifo_stack.
module testbench;
    import bls_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Directed table row: a request or a capacity write
    localparam logic ROW_REQ   = 1'b0;
    localparam logic ROW_CAP   = 1'b1;
    localparam logic CHK_MODEL = 1'b0;
    localparam logic CHK_FIXED = 1'b1;

    typedef struct packed {
        logic                kind;
        logic                fixed;
        logic [CAP_BITS-1:0] cap;
        t_req                req;
        t_rsp                want;
    } t_row;

    localparam int N_DIRECTED = 26;
    localparam t_row DIRECTED [N_DIRECTED] = '{
        // empty stack after reset
        '{ROW_REQ, CHK_FIXED, 9'd0, '{ACT_POP,  32'h0, 9'd0},   '{ERR_DATA, ST_EMPTY, 9'd0}},
        '{ROW_REQ, CHK_FIXED, 9'd0, '{ACT_PEEK, 32'h0, 9'd0},   '{ERR_DATA, ST_EMPTY, 9'd0}},
        '{ROW_REQ, CHK_FIXED, 9'd0, '{ACT_READ, 32'h0, 9'd1},   '{ERR_DATA, ST_EMPTY, 9'd0}},
        // extreme words, then reads at good and bad positions
        '{ROW_REQ, CHK_FIXED, 9'd0, '{ACT_PUSH, 32'h7FFFFFFF, 9'd0},
          '{ERR_DATA, ST_OK, 9'd1}},
        '{ROW_REQ, CHK_FIXED, 9'd0, '{ACT_PUSH, 32'h80000000, 9'd0},
          '{ERR_DATA, ST_OK, 9'd2}},
        '{ROW_REQ, CHK_FIXED, 9'd0, '{ACT_PEEK, 32'h0, 9'd0},   '{32'h80000000, ST_OK, 9'd2}},
        '{ROW_REQ, CHK_FIXED, 9'd0, '{ACT_READ, 32'h0, 9'd2},   '{32'h7FFFFFFF, ST_OK, 9'd2}},
        '{ROW_REQ, CHK_FIXED, 9'd0, '{ACT_READ, 32'h0, 9'd0},   '{ERR_DATA, ST_BADPOS, 9'd2}},
        '{ROW_REQ, CHK_FIXED, 9'd0, '{ACT_READ, 32'h0, 9'd3},   '{ERR_DATA, ST_BADPOS, 9'd2}},
        '{ROW_REQ, CHK_FIXED, 9'd0, '{ACT_READ, 32'h0, 9'd511}, '{ERR_DATA, ST_BADPOS, 9'd2}},
        '{ROW_REQ, CHK_MODEL, 9'd0, '{ACT_PUSH, 32'hFFFFFFFF, 9'd0}, '0},
        '{ROW_REQ, CHK_MODEL, 9'd0, '{ACT_PUSH, 32'h0, 9'd511},      '0},
        // capacity dropped below the fill: pushes blocked, pops still work
        '{ROW_CAP, CHK_MODEL, 9'd3, '0, '0},
        '{ROW_REQ, CHK_FIXED, 9'd0, '{ACT_PUSH, 32'h5, 9'd0},   '{ERR_DATA, ST_OVERFLOW, 9'd4}},
        '{ROW_REQ, CHK_FIXED, 9'd0, '{ACT_POP,  32'h0, 9'd0},   '{32'h0, ST_OK, 9'd3}},
        '{ROW_REQ, CHK_FIXED, 9'd0, '{ACT_PUSH, 32'h12345678, 9'd0},
          '{ERR_DATA, ST_OVERFLOW, 9'd3}},
        // zero capacity refuses every push
        '{ROW_CAP, CHK_MODEL, 9'd0, '0, '0},
        '{ROW_REQ, CHK_FIXED, 9'd0, '{ACT_POP,  32'h0, 9'd0},   '{32'hFFFFFFFF, ST_OK, 9'd2}},
        '{ROW_REQ, CHK_FIXED, 9'd0, '{ACT_PUSH, 32'hAAAAAAAA, 9'd0},
          '{ERR_DATA, ST_OVERFLOW, 9'd2}},
        // capacity beyond the store is clamped
        '{ROW_CAP, CHK_MODEL, 9'd511, '0, '0},
        '{ROW_REQ, CHK_FIXED, 9'd0, '{ACT_PUSH, 32'h55555555, 9'd0},
          '{ERR_DATA, ST_OK, 9'd3}},
        '{ROW_REQ, CHK_MODEL, 9'd0, '{ACT_READ, 32'h0, 9'd1},   '0},
        '{ROW_REQ, CHK_FIXED, 9'd0, '{ACT_POP,  32'h0, 9'd0},   '{32'h55555555, ST_OK, 9'd2}},
        '{ROW_REQ, CHK_FIXED, 9'd0, '{ACT_POP,  32'h0, 9'd0},   '{32'h80000000, ST_OK, 9'd1}},
        '{ROW_REQ, CHK_FIXED, 9'd0, '{ACT_POP,  32'h0, 9'd0},   '{32'h7FFFFFFF, ST_OK, 9'd0}},
        '{ROW_REQ, CHK_FIXED, 9'd0, '{ACT_POP,  32'h0, 9'd0},   '{ERR_DATA, ST_EMPTY, 9'd0}}
    };

    // Random phases: capacity, push and pop weights in percent, request count
    localparam int N_PHASES = 8;
    localparam logic [CAP_BITS-1:0] PHASE_CAP [N_PHASES] =
        '{9'd256, 9'd100, 9'd1, 9'd0, 9'd2, 9'd511, 9'd257, 9'd0};
    localparam int PHASE_PUSH  [N_PHASES] = '{90, 3, 45, 30, 40, 60, 15, 35};
    localparam int PHASE_POP   [N_PHASES] = '{5, 90, 40, 40, 35, 20, 50, 35};
    localparam int PHASE_ITEMS [N_PHASES] = '{300, 300, 100, 100, 100, 150, 100, 150};

    localparam int DRAIN_CYCLES = 8;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    t_req                req;
    logic                rsp_valid;
    logic                rsp_stall;
    t_rsp                rsp;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CAP_BITS-1:0] cfg_data;

    // Stack model state
    logic [DATA_BITS-1:0] stack_words [DEF_MAX_DEPTH];
    int                   stack_fill;
    int                   cap_setting;

    t_rsp due_replies [$];
    int   mismatches;

    bounded_lifo_stack dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_stall (req_stall),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_stall (rsp_stall),
        .o_rsp       (rsp),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Apply one request to the model and return the reply it should give
    function automatic t_rsp stack_reply(input t_req r);
        t_rsp reply;
        int   usable;
        reply.read_data = ERR_DATA;
        reply.status    = ST_OK;
        usable = (cap_setting > DEF_MAX_DEPTH) ? DEF_MAX_DEPTH : cap_setting;
        case (r.action)
            ACT_PUSH: begin
                if (stack_fill >= usable) begin
                    reply.status = ST_OVERFLOW;
                end else begin
                    stack_words[stack_fill] = r.push_value;
                    stack_fill++;
                end
            end
            ACT_POP: begin
                if (stack_fill == 0) begin
                    reply.status = ST_EMPTY;
                end else begin
                    stack_fill--;
                    reply.read_data = stack_words[stack_fill];
                end
            end
            ACT_PEEK: begin
                if (stack_fill == 0) reply.status = ST_EMPTY;
                else reply.read_data = stack_words[stack_fill - 1];
            end
            default: begin
                if (stack_fill == 0) reply.status = ST_EMPTY;
                else if (r.position == 0 || int'(r.position) > stack_fill)
                    reply.status = ST_BADPOS;
                else reply.read_data = stack_words[stack_fill - int'(r.position)];
            end
        endcase
        reply.entry_count = CAP_BITS'(stack_fill);
        return reply;
    endfunction

    // Mostly back-to-back, sometimes a short gap, rarely a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // One request transfer; the reply is queued once the transfer is taken
    task automatic send_request(input t_req r, input logic fixed, input t_rsp want);
        t_rsp modelled;
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (req_stall);
        modelled = stack_reply(r);
        due_replies.push_back(fixed ? want : modelled);
    endtask

    task automatic idle_requests(input int cycles);
        if (cycles > 0) begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Capacity is only changed with the pipeline drained
    task automatic write_capacity(input logic [CAP_BITS-1:0] value);
        @(negedge clk);
        req_valid <= 1'b0;
        while (due_replies.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cap_setting = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Response back-pressure: runs of stall and release of random length
    initial begin : rsp_backpressure
        int hold;
        int roll;
        rsp_stall = 1'b0;
        hold = 0;
        forever begin
            @(negedge clk);
            if (hold > 0) begin
                hold--;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 35) begin
                    rsp_stall <= 1'b1;
                    hold = (roll < 30) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                end else begin
                    rsp_stall <= 1'b0;
                    hold = (roll < 90) ? $urandom_range(0, 12) : $urandom_range(40, 120);
                end
            end
        end
    end

    // Compare every response transfer with the oldest queued reply
    always @(posedge clk) begin : reply_check
        t_rsp want;
        if (rst_n && rsp_valid === 1'b1 && !rsp_stall) begin
            if (due_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: response with none pending: data %h status %0d count %0d",
                             $time, rsp.read_data, rsp.status, rsp.entry_count);
            end else begin
                want = due_replies.pop_front();
                if (rsp.read_data !== want.read_data || rsp.status !== want.status
                    || rsp.entry_count !== want.entry_count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                                 $time, want.read_data, want.status, want.entry_count,
                                 rsp.read_data, rsp.status, rsp.entry_count);
                end
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        t_row row;
        t_req r;
        int   ph;
        int   k;
        int   roll;
        int   burst_left;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        stack_fill  = 0;
        cap_setting = CAP_RESET;
        mismatches  = 0;
        burst_left  = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table
        for (k = 0; k < N_DIRECTED; k++) begin
            row = DIRECTED[k];
            if (row.kind == ROW_CAP) begin
                write_capacity(row.cap);
            end else begin
                send_request(row.req, row.fixed, row.want);
                idle_requests(pick_gap());
            end
        end

        // Random phases; the last one takes a random capacity
        for (ph = 0; ph < N_PHASES; ph++) begin
            write_capacity((ph == N_PHASES - 1) ? CAP_BITS'($urandom_range(1, 256))
                                                : PHASE_CAP[ph]);
            for (k = 0; k < PHASE_ITEMS[ph]; k++) begin
                r.push_value = $urandom;
                r.position   = CAP_BITS'($urandom_range(0, 511));
                roll = $urandom_range(0, 99);
                if (roll < PHASE_PUSH[ph]) r.action = ACT_PUSH;
                else if (roll < PHASE_PUSH[ph] + PHASE_POP[ph]) r.action = ACT_POP;
                else r.action = $urandom_range(0, 1) ? ACT_PEEK : ACT_READ;
                // reads mostly hit a held entry, some go to zero or past the top
                if (r.action == ACT_READ) begin
                    roll = $urandom_range(0, 9);
                    if (roll < 7)
                        r.position = CAP_BITS'($urandom_range(1,
                                                  (stack_fill > 0) ? stack_fill : 1));
                    else if (roll == 7)
                        r.position = '0;
                    else if (roll == 8)
                        r.position = CAP_BITS'($urandom_range(stack_fill + 1, 511));
                end
                send_request(r, CHK_MODEL, '0);
                // occasional stretches with no gaps at all
                if (k % 64 == 0) burst_left = ($urandom_range(0, 3) == 0) ? 40 : 0;
                if (burst_left > 0) burst_left--;
                else idle_requests(pick_gap());
            end
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (due_replies.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
